// ----- rtl/rpn_pkg.sv -----
// Package for the RPN stack calculator: transaction types, opcode and status codes.
package rpn_pkg;

    // Opcodes of a command transaction
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // Status codes of a result transaction
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FEW     = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Data word width and iteration counter width of the shared unit
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 5;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] push_value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [1:0]         status;
        logic [4:0]         stack_count;
    } t_rsp;

endpackage

// ----- rtl/rpn_stack_calculator.sv -----
// RPN stack calculator top level: sequencer, stack memory and shared add/subtract unit.
//
// Usage:
//   A command transaction (i_cmd) is taken at a rising edge where start is high
//   and busy is low. busy stays high until the command has finished.
//   Each command gives exactly one result transaction on o_rsp, marked by
//   o_valid for a single cycle; the receiver cannot stall it.
//   Push, an unused opcode and too few operands go from idle straight to the
//   finish state; add, subtract and divide by zero pass through the load state
//   first, and multiply and divide then also run the iteration state. A new
//   command is not taken before the last one has given its result.
//   Multiply (shift-add) and divide (restoring, one quotient bit per cycle)
//   run 32 passes through one 34-bit adder; that loop sets the worst case.
//   The next command may be given in the cycle that o_valid is high.
//   The top of stack is kept in a register; the entry below it is read from
//   the stack memory (registered read) when a command is accepted.
//   Reset is synchronous and active low: it empties the stack and idles the
//   sequencer. Stack memory contents are not cleared; entries above the
//   depth are never used.
module rpn_stack_calculator #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rpn_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_valid,
    output rpn_pkg::t_rsp o_rsp
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam logic [rpn_pkg::CNT_W-1:0] ITER_LAST = '1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_ITER = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Command and control registers
    logic [2:0]                 r_op;
    logic [31:0]                r_push;
    logic [1:0]                 r_status;
    logic [DW-1:0]              r_depth, n_depth;
    logic [31:0]                r_top, n_top;
    logic [rpn_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_valid;
    rpn_pkg::t_rsp              r_rsp;

    // Shared unit operands and state
    logic [31:0] r_a;      // multiplicand / dividend-quotient shift register
    logic [31:0] r_b;      // multiplier / divisor magnitude
    logic [31:0] r_acc;    // product accumulator / add-sub result
    logic [32:0] r_rem;    // partial remainder
    logic        r_neg;    // quotient sign

    // Stack memory
    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;

    logic          accept;
    logic [DW-1:0] depth_m2;
    logic          is_arith;
    logic [32:0]   rem_sh;
    logic          commit;
    logic [31:0]   result;
    logic [DW+4:0] cnt_ext;

    // Shared 34-bit adder
    logic [33:0] add_x, add_y, add_sum;
    logic        add_sub;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign depth_m2 = r_depth - DW'(2);
    assign is_arith = (r_op == rpn_pkg::OP_ADD) || (r_op == rpn_pkg::OP_SUB) ||
                      (r_op == rpn_pkg::OP_MUL) || (r_op == rpn_pkg::OP_DIV);
    assign rem_sh   = {r_rem[31:0], r_a[31]};

    // Operand selection for the shared adder
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                add_x   = {2'b00, r_rdata};
                add_y   = {2'b00, r_top};
                add_sub = (r_op == rpn_pkg::OP_SUB);
            end
            S_ITER: begin
                if (r_op == rpn_pkg::OP_DIV) begin
                    add_x   = {1'b0, rem_sh};
                    add_y   = {2'b00, r_b};
                    add_sub = 1'b1;
                end else begin
                    add_x   = {2'b00, r_acc};
                    add_y   = r_b[0] ? {2'b00, r_a} : '0;
                end
            end
            S_FIN: begin
                // negate the quotient magnitude
                add_y   = {2'b00, r_a};
                add_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + 34'(add_sub);

    // Final result and stack update
    always_comb begin
        if (r_op == rpn_pkg::OP_DIV) begin
            result = r_neg ? add_sum[31:0] : r_a;
        end else begin
            result = r_acc;
        end
        commit    = (r_state == S_FIN) && (r_status == rpn_pkg::ST_OK) &&
                    ((r_op == rpn_pkg::OP_PUSH) || is_arith);
        mem_we    = commit;
        n_top     = r_top;
        n_depth   = r_depth;
        mem_waddr = depth_m2[AW-1:0];
        mem_wdata = result;
        if (commit) begin
            if (r_op == rpn_pkg::OP_PUSH) begin
                mem_waddr = r_depth[AW-1:0];
                mem_wdata = r_push;
                n_top     = r_push;
                n_depth   = r_depth + DW'(1);
            end else begin
                n_top     = result;
                n_depth   = r_depth - DW'(1);
            end
        end
    end

    assign cnt_ext = {5'b00000, n_depth};

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_cmd.opcode == rpn_pkg::OP_ADD) || (i_cmd.opcode == rpn_pkg::OP_SUB) ||
                        (i_cmd.opcode == rpn_pkg::OP_MUL) || (i_cmd.opcode == rpn_pkg::OP_DIV)) begin
                        n_state = (r_depth < DW'(2)) ? S_FIN : S_LOAD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LOAD: begin
                if ((r_op == rpn_pkg::OP_MUL) ||
                    ((r_op == rpn_pkg::OP_DIV) && (r_top != '0))) begin
                    n_state = S_ITER;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ITER: begin
                if (r_cnt == ITER_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_valid <= (r_state == S_FIN);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op     <= i_cmd.opcode;
                    r_push   <= i_cmd.push_value;
                    if (i_cmd.opcode == rpn_pkg::OP_PUSH) begin
                        r_status <= (r_depth == DW'(STACK_DEPTH)) ? rpn_pkg::ST_FULL :
                                                                    rpn_pkg::ST_OK;
                    end else if ((i_cmd.opcode == rpn_pkg::OP_ADD) ||
                                 (i_cmd.opcode == rpn_pkg::OP_SUB) ||
                                 (i_cmd.opcode == rpn_pkg::OP_MUL) ||
                                 (i_cmd.opcode == rpn_pkg::OP_DIV)) begin
                        r_status <= (r_depth < DW'(2)) ? rpn_pkg::ST_FEW : rpn_pkg::ST_OK;
                    end else begin
                        r_status <= rpn_pkg::ST_OK;
                    end
                end
            end
            S_LOAD: begin
                r_cnt <= '0;
                r_rem <= '0;
                if (r_op == rpn_pkg::OP_MUL) begin
                    r_a   <= r_rdata;
                    r_b   <= r_top;
                    r_acc <= '0;
                end else begin
                    r_acc <= add_sum[31:0];
                    if (r_op == rpn_pkg::OP_DIV) begin
                        // operand magnitudes and quotient sign
                        r_a   <= r_rdata[31] ? (32'd0 - r_rdata) : r_rdata;
                        r_b   <= r_top[31] ? (32'd0 - r_top) : r_top;
                        r_neg <= r_rdata[31] ^ r_top[31];
                        if (r_top == '0) begin
                            r_status <= rpn_pkg::ST_DIVZERO;
                        end
                    end
                end
            end
            S_ITER: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_op == rpn_pkg::OP_DIV) begin
                    r_rem <= add_sum[33] ? rem_sh : add_sum[32:0];
                    r_a   <= {r_a[30:0], ~add_sum[33]};
                end else begin
                    r_acc <= add_sum[31:0];
                    r_a   <= {r_a[30:0], 1'b0};
                    r_b   <= {1'b0, r_b[31:1]};
                end
            end
            S_FIN: begin
                r_rsp.top_value   <= (n_depth != '0) ? n_top : '0;
                r_rsp.status      <= r_status;
                r_rsp.stack_count <= cnt_ext[4:0];
            end
            default: begin
            end
        endcase
    end

    // Stack memory: one write port, one registered read at depth minus two
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[depth_m2[AW-1:0]];
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTHESIS
    // A result is only shown once the sequencer is back in idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted command always occupies the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted command did not raise busy");

    // Depth never exceeds the stack size
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth out of range");

    // Full status only when the stack is at its limit
    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == rpn_pkg::ST_FULL)) |-> (r_depth == DW'(STACK_DEPTH)))
        else $error("full status with room on stack");

    // Empty stack reports a zero top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_depth == '0)) |-> (o_rsp.top_value == '0))
        else $error("nonzero top on empty stack");
`endif

endmodule
